// ----- hdl/cbpa_pkg.sv -----
// Package for the counted block pool allocator.
// Holds field widths, operation and register codes, and the control/status structs.
// No dependencies.
package cbpa_pkg;

  localparam int MAX_BLOCKS_DEF = 256;
  localparam int BMP_W          = 32;
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 16;
  localparam int COUNT_W        = 9;
  localparam int START_W        = 16;
  localparam int IDXO_W         = 8;
  localparam int KIND_W         = 2;
  localparam int REG_W          = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd2;

  localparam logic [REG_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [REG_W-1:0] REG_COUNT = 2'd2;

  localparam logic [COUNT_W-1:0] USED_MAX   = 9'd511;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]  SIZE_RST   = 16'd1;

  typedef struct packed {
    logic load_in;
    logic scan_init;
    logic rd_row;
    logic scan_adv;
    logic scan_hit;
    logic scan_fail;
    logic div_start;
    logic free_sel;
    logic free_hit;
    logic mul;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              pool_empty;
    logic              below_base;
    logic              row_hit;
    logic              scan_last;
    logic              div_done;
    logic              q_in_range;
    logic              bit_set;
  } sts_t;

endpackage

// ----- hdl/counted_block_pool_allocator_top.sv -----
// Top level of the counted block pool allocator: controller, datapath, config port.
// Depends on cbpa_pkg, cbpa_ctrl and cbpa_dp.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_stall    in_kind, in_address, in_start_index
//   out      out        out_valid / out_stall  out_block_address, out_block_index,
//                                              out_found, out_allocated_count
//
// Allocate and get-next read one 32-bit bitmap row per scan step (S_SRD, S_SCHK),
// visiting at most MAX_BLOCKS/32 + 1 rows.
// Free waits on the one-bit-per-cycle divider (32 steps).
// Reset clears the per-row valid bits at once; no clearing pass is needed.
// A finished transaction waits in the output register while the next one is taken;
// a stalled result holds the controller only when the next result is ready.
module counted_block_pool_allocator_top #(
  parameter int MAX_BLOCKS = cbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbpa_pkg::REG_W-1:0]     cfg_index,
  input  logic [cbpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbpa_pkg::KIND_W-1:0]    in_kind,
  input  logic [cbpa_pkg::ADDR_W-1:0]    in_address,
  input  logic [cbpa_pkg::START_W-1:0]   in_start_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic [cbpa_pkg::IDXO_W-1:0]    out_block_index,
  output logic                           out_found,
  output logic [cbpa_pkg::COUNT_W-1:0]   out_allocated_count
);

  cbpa_pkg::cmd_t ctl_cmd;
  cbpa_pkg::sts_t dp_sts;

  assign cfg_ready = 1'b1;

  cbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (ctl_cmd)
  );

  cbpa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_kind             (in_kind),
    .in_address          (in_address),
    .in_start_index      (in_start_index),
    .cmd                 (ctl_cmd),
    .sts                 (dp_sts),
    .out_block_address   (out_block_address),
    .out_block_index     (out_block_index),
    .out_found           (out_found),
    .out_allocated_count (out_allocated_count)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction taken while one is in progress");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_block_index == '0) && (out_block_address == '0)))
    else $error("result without a block carries a nonzero index or address");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register loaded over a waiting result");
`endif

endmodule

// ----- hdl/cbpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cbpa_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                      wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                      rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/cbpa_div.sv -----
// Restoring divider, one quotient bit per cycle, for address-to-index decoding.
// Depends on cbpa_pkg.
module cbpa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cbpa_pkg::ADDR_W-1:0]   dividend,
  input  logic [cbpa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [cbpa_pkg::ADDR_W-1:0]   quotient
);

  localparam int A_W = cbpa_pkg::ADDR_W;
  localparam int S_W = cbpa_pkg::SIZE_W;
  localparam int C_W = $clog2(A_W);

  logic           busy_r;
  logic           done_r;
  logic [C_W-1:0] cnt_r;
  logic [S_W-1:0] rem_r;
  logic [A_W-1:0] quo_r;
  logic [S_W-1:0] dvs_r;

  logic [S_W:0]   sh_w;
  logic           qbit_w;
  logic [S_W-1:0] rem_nxt;

  always_comb begin
    sh_w = {rem_r, quo_r[A_W-1]};
    qbit_w = (sh_w >= {1'b0, dvs_r});
    if (qbit_w) begin
      rem_nxt = S_W'(sh_w - {1'b0, dvs_r});
    end else begin
      rem_nxt = S_W'(sh_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == C_W'(A_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[A_W-2:0], qbit_w};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- hdl/cbpa_dp.sv -----
// Datapath: configuration registers, occupancy bitmap rows, word scan, cursor,
// block count, address arithmetic and result register. Depends on cbpa_pkg,
// cbpa_ram and cbpa_div.
module cbpa_dp #(
  parameter int MAX_BLOCKS = cbpa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cbpa_pkg::REG_W-1:0]     cfg_index,
  input  logic [cbpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic [cbpa_pkg::KIND_W-1:0]    in_kind,
  input  logic [cbpa_pkg::ADDR_W-1:0]    in_address,
  input  logic [cbpa_pkg::START_W-1:0]   in_start_index,
  input  cbpa_pkg::cmd_t                 cmd,
  output cbpa_pkg::sts_t                 sts,
  output logic [cbpa_pkg::ADDR_W-1:0]    out_block_address,
  output logic [cbpa_pkg::IDXO_W-1:0]    out_block_index,
  output logic                           out_found,
  output logic [cbpa_pkg::COUNT_W-1:0]   out_allocated_count
);

  localparam int A_W   = cbpa_pkg::ADDR_W;
  localparam int S_W   = cbpa_pkg::SIZE_W;
  localparam int CNT_W = cbpa_pkg::COUNT_W;
  localparam int ST_W  = cbpa_pkg::START_W;
  localparam int IO_W  = cbpa_pkg::IDXO_W;
  localparam int W     = cbpa_pkg::BMP_W;
  localparam int BW    = $clog2(W);
  localparam int ROWS  = (MAX_BLOCKS + W - 1) / W;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = 1 << RA_W;
  localparam int GW    = RA_W + BW;
  localparam int NW    = $clog2(MAX_BLOCKS + 1);
  localparam int CW    = (NW > CNT_W) ? NW : CNT_W;
  localparam int KW0   = (GW > ST_W) ? GW : ST_W;
  localparam int KW    = (KW0 > CW) ? KW0 : CW;
  localparam int PW    = GW + S_W;

  logic [cbpa_pkg::KIND_W-1:0] kind_r;
  logic [A_W-1:0]   addr_r;
  logic [ST_W-1:0]  start_r;
  logic [A_W-1:0]   base_r;
  logic [S_W-1:0]   bsize_r;
  logic [CNT_W-1:0] bcount_r;
  logic [GW-1:0]    cursor_r;
  logic [CNT_W-1:0] used_r;
  logic [DEPTH-1:0] row_vld_r;
  logic             rvq_r;
  logic [GW-1:0]    s_r;
  logic [RA_W-1:0]  row_r;
  logic             pass_r;
  logic [GW-1:0]    hit_idx_r;
  logic             res_found_r;
  logic [IO_W-1:0]  res_idx_r;
  logic [A_W-1:0]   res_addr_r;
  logic [A_W-1:0]   prod_r;
  logic [A_W-1:0]   oaddr_r;
  logic [IO_W-1:0]  oidx_r;
  logic             ofound_r;
  logic [CNT_W-1:0] ocount_r;

  logic [NW-1:0]    n_w;
  logic [S_W-1:0]   size_w;
  logic [GW-1:0]    nm1_w;
  logic [RA_W-1:0]  last_row_w;
  logic [W-1:0]     ram_q;
  logic [W-1:0]     word_w;
  logic             tgt_w;
  logic [W-1:0]     cand_w;
  logic             hit_any_w;
  logic [BW-1:0]    hit_j_w;
  logic [GW-1:0]    g_hit_w;
  logic [GW-1:0]    s_sel_w;
  logic             is_alloc_w;
  logic             ram_we_w;
  logic [W-1:0]     ram_wd_w;
  logic [A_W-1:0]   div_q;
  logic             div_done;
  logic [GW-1:0]    q_idx_w;
  logic [PW-1:0]    prod_w;

  always_comb begin
    if (CW'(bcount_r) > CW'(MAX_BLOCKS)) begin
      n_w = NW'(MAX_BLOCKS);
    end else begin
      n_w = NW'(bcount_r);
    end
  end

  assign size_w     = (bsize_r == '0) ? S_W'(1) : bsize_r;
  assign nm1_w      = GW'(n_w - 1'b1);
  assign last_row_w = nm1_w[GW-1:BW];
  assign is_alloc_w = (kind_r == cbpa_pkg::KIND_ALLOC);
  assign tgt_w      = (kind_r == cbpa_pkg::KIND_NEXT);
  assign word_w     = rvq_r ? ram_q : '0;
  assign q_idx_w    = GW'(div_q);
  assign prod_w     = PW'(hit_idx_r) * PW'(bsize_r);

  always_comb begin
    if (is_alloc_w) begin
      s_sel_w = (KW'(cursor_r) < KW'(n_w)) ? cursor_r : '0;
    end else begin
      s_sel_w = (KW'(start_r) < KW'(n_w)) ? GW'(start_r) : '0;
    end
  end

  always_comb begin : cand_blk
    logic [GW-1:0] g;
    logic          in_rng;
    for (int j = 0; j < W; j++) begin
      g = {row_r, BW'(j)};
      in_rng = pass_r ? (g < s_r) : (g >= s_r);
      cand_w[j] = (KW'(g) < KW'(n_w)) && in_rng && (word_w[j] == tgt_w);
    end
  end

  always_comb begin
    hit_any_w = 1'b0;
    hit_j_w   = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (cand_w[j]) begin
        hit_any_w = 1'b1;
        hit_j_w   = BW'(j);
      end
    end
  end

  assign g_hit_w = {row_r, hit_j_w};

  always_comb begin
    ram_we_w = 1'b0;
    ram_wd_w = word_w;
    if (cmd.scan_hit && is_alloc_w) begin
      ram_we_w = 1'b1;
      ram_wd_w = word_w | (W'(1) << hit_j_w);
    end else if (cmd.free_hit) begin
      ram_we_w = 1'b1;
      ram_wd_w = word_w & ~(W'(1) << hit_idx_r[BW-1:0]);
    end
  end

  cbpa_ram #(
    .DATA_W (W),
    .DEPTH  (DEPTH)
  ) u_bmp (
    .clk   (clk),
    .we    (ram_we_w),
    .waddr (row_r),
    .wdata (ram_wd_w),
    .re    (cmd.rd_row),
    .raddr (row_r),
    .rdata (ram_q)
  );

  cbpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (addr_r - base_r),
    .divisor  (size_w),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      bsize_r   <= cbpa_pkg::SIZE_RST;
      bcount_r  <= cbpa_pkg::COUNT_RST;
      cursor_r  <= '0;
      used_r    <= '0;
      row_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbpa_pkg::REG_BASE: begin
            base_r <= cfg_data;
          end
          cbpa_pkg::REG_SIZE: begin
            bsize_r <= cfg_data[S_W-1:0];
          end
          cbpa_pkg::REG_COUNT: begin
            bcount_r <= cfg_data[CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_hit && is_alloc_w) begin
        cursor_r         <= g_hit_w;
        row_vld_r[row_r] <= 1'b1;
        if (used_r != cbpa_pkg::USED_MAX) begin
          used_r <= used_r + 1'b1;
        end
      end
      if (cmd.scan_fail && is_alloc_w) begin
        cursor_r <= '0;
      end
      if (cmd.free_hit && (used_r != '0)) begin
        used_r <= used_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r      <= in_kind;
      addr_r      <= in_address;
      start_r     <= in_start_index;
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
      res_addr_r  <= '0;
    end
    if (cmd.scan_init) begin
      s_r    <= s_sel_w;
      row_r  <= s_sel_w[GW-1:BW];
      pass_r <= 1'b0;
    end
    if (cmd.scan_adv) begin
      if (!pass_r && (row_r == last_row_w)) begin
        pass_r <= 1'b1;
        row_r  <= '0;
      end else begin
        row_r <= row_r + 1'b1;
      end
    end
    if (cmd.rd_row) begin
      rvq_r <= row_vld_r[row_r];
    end
    if (cmd.scan_hit) begin
      hit_idx_r   <= g_hit_w;
      res_found_r <= 1'b1;
      res_idx_r   <= IO_W'(g_hit_w);
    end
    if (cmd.free_sel) begin
      hit_idx_r <= q_idx_w;
      row_r     <= q_idx_w[GW-1:BW];
    end
    if (cmd.free_hit) begin
      res_found_r <= 1'b1;
      res_idx_r   <= IO_W'(hit_idx_r);
    end
    if (cmd.mul) begin
      prod_r <= A_W'(prod_w);
    end
    if (cmd.add) begin
      res_addr_r <= base_r + prod_r;
    end
    if (cmd.out_load) begin
      oaddr_r  <= res_addr_r;
      oidx_r   <= res_idx_r;
      ofound_r <= res_found_r;
      ocount_r <= used_r;
    end
  end

  always_comb begin
    sts.kind       = kind_r;
    sts.pool_empty = (n_w == '0);
    sts.below_base = (addr_r < base_r);
    sts.row_hit    = hit_any_w;
    sts.scan_last  = pass_r ? (row_r == s_r[GW-1:BW])
                            : ((row_r == last_row_w) && (s_r == '0));
    sts.div_done   = div_done;
    sts.q_in_range = (div_q < A_W'(n_w));
    sts.bit_set    = word_w[hit_idx_r[BW-1:0]];
  end

  assign out_block_address   = oaddr_r;
  assign out_block_index     = oidx_r;
  assign out_found           = ofound_r;
  assign out_allocated_count = ocount_r;

endmodule

// ----- hdl/cbpa_ctrl.sv -----
// Controller state machine: sequences decode, bitmap scan, divide, update and result.
// Depends on cbpa_pkg.
module cbpa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  cbpa_pkg::sts_t sts,
  output cbpa_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_SRD,
    S_SCHK,
    S_DIV,
    S_FRD,
    S_FCHK,
    S_MUL,
    S_ADD,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        priority if ((sts.kind == cbpa_pkg::KIND_ALLOC) ||
                     (sts.kind == cbpa_pkg::KIND_NEXT)) begin
          if (sts.pool_empty) begin
            cmd.scan_fail = 1'b1;
            state_nxt     = S_FIN;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SRD;
          end
        end else if (sts.kind == cbpa_pkg::KIND_FREE) begin
          if (sts.below_base) begin
            state_nxt = S_FIN;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SRD: begin
        cmd.rd_row = 1'b1;
        state_nxt  = S_SCHK;
      end
      S_SCHK: begin
        priority if (sts.row_hit) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = S_MUL;
        end else if (sts.scan_last) begin
          cmd.scan_fail = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.scan_adv = 1'b1;
          state_nxt    = S_SRD;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.q_in_range) begin
            cmd.free_sel = 1'b1;
            state_nxt    = S_FRD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FRD: begin
        cmd.rd_row = 1'b1;
        state_nxt  = S_FCHK;
      end
      S_FCHK: begin
        cmd.free_hit = sts.bit_set;
        state_nxt    = S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
